// ===== rtl/srripfo_pkg.sv =====
`default_nettype none

package srripfo_pkg;

  // Fixed field widths of the request and response items.
  localparam int unsigned OpW      = 2;
  localparam int unsigned SetInW   = 10;
  localparam int unsigned WayInW   = 4;
  localparam int unsigned WayOutW  = 4;
  localparam int unsigned RankOutW = 5;

  localparam int unsigned NumSetsDef = 1024;
  localparam int unsigned NumWaysDef = 16;

  localparam logic [1:0] RerefHit  = 2'd3;
  localparam logic [1:0] RerefFill = 2'd1;

  typedef enum logic [OpW-1:0] {
    OP_HIT    = 2'd0,
    OP_VICTIM = 2'd1,
    OP_FILL   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_LOAD,
    ST_PASS1,
    ST_PASS2,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [SetInW-1:0] set_index;
    logic [WayInW-1:0] way_index;
  } req_t;

  typedef struct packed {
    logic [WayOutW-1:0]  victim_way;
    logic [RankOutW-1:0] fill_rank;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/srripfo_req_if.sv =====
`default_nettype none

interface srripfo_req_if;
  logic                valid;
  logic                ready;
  srripfo_pkg::req_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/srripfo_rsp_if.sv =====
`default_nettype none

interface srripfo_rsp_if;
  logic                valid;
  logic                ready;
  srripfo_pkg::rsp_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/srrip_replacement_with_fill_order_top.sv =====
// Channel  | Dir | Payload                               | Handshake
// req_i    | in  | operation, set_index, way_index       | valid/ready
// rsp_o    | out | victim_way, fill_rank                 | valid/ready
//
// An accepted item passes set reduction (only when NUM_SETS is below 1024), a row read,
// a row load, two passes over the rotating set row and a write-back. Both passes go
// through the single per-way update unit, which visits the rotating set row twice.
// After reset a clearing pass writes every set row, one per cycle,
// and no item is accepted until it ends. A stalled result holds in the output
// register; the next item may be accepted meanwhile and waits before write-back.
`default_nettype none

module srrip_replacement_with_fill_order_top #(
  parameter int unsigned NUM_SETS = srripfo_pkg::NumSetsDef,
  parameter int unsigned NUM_WAYS = srripfo_pkg::NumWaysDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  srripfo_req_if.sink          req_i,
  srripfo_rsp_if.source        rsp_o
);

  localparam int unsigned SetInW   = srripfo_pkg::SetInW;
  localparam int unsigned SetAw    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned RankW    = $clog2(NUM_WAYS + 1);
  localparam int unsigned WayCntW  = $clog2(NUM_WAYS);
  localparam int unsigned WayCmpW  = ($clog2(NUM_WAYS + 1) > srripfo_pkg::WayInW) ?
                                     $clog2(NUM_WAYS + 1) : srripfo_pkg::WayInW;
  localparam int unsigned RowW     = NUM_WAYS * (2 + RankW);
  localparam int unsigned CmpW     = SetInW + $clog2(NUM_SETS + 1);
  localparam int unsigned ModCntW  = $clog2(SetInW);
  localparam bit          NeedMod  = (NUM_SETS < (2 ** SetInW));

  srripfo_pkg::state_e state_q, state_d;

  logic                              out_valid_q;
  srripfo_pkg::rsp_t                 out_data_q;
  logic [SetAw-1:0]                  clr_q;
  logic [WayCntW-1:0]                way_cnt_q;
  logic [ModCntW-1:0]                mod_k_q;

  srripfo_pkg::op_e                  op_q;
  logic [SetInW-1:0]                 set_q;
  logic [srripfo_pkg::WayInW-1:0]    way_q;
  logic                              way_ok_q;
  logic [1:0]                        min_q;
  logic [RankW-1:0]                  old_rank_q;
  logic [RankW-1:0]                  res_rank_q;
  logic                              found_q;
  logic [WayCntW-1:0]                victim_q;

  logic [1:0]                        val_q  [NUM_WAYS];
  logic [RankW-1:0]                  rank_q [NUM_WAYS];

  logic [RowW-1:0]                   mem [NUM_SETS];
  logic [RowW-1:0]                   rdata_q;
  logic [RowW-1:0]                   row_packed;
  logic [RowW-1:0]                   row_reset;
  logic                              mem_we;
  logic                              mem_re;
  logic [SetAw-1:0]                  mem_addr;

  logic                              accept;
  logic                              way_last;
  logic                              match;
  logic [1:0]                        head_v;
  logic [RankW-1:0]                  head_r;
  logic [1:0]                        new_v;
  logic [RankW-1:0]                  new_r;
  logic [CmpW-1:0]                   mod_sub;
  logic                              out_free;

  assign accept    = req_i.valid && req_i.ready;
  assign way_last  = (way_cnt_q == WayCntW'(NUM_WAYS - 1));
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign mod_sub   = CmpW'(NUM_SETS) << mod_k_q;

  assign req_i.ready = (state_q == srripfo_pkg::ST_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  // Row layout: all values in the low part, all ranks above them.
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      row_packed[w*2 +: 2]                    = val_q[w];
      row_packed[NUM_WAYS*2 + w*RankW +: RankW] = rank_q[w];
      row_reset[w*2 +: 2]                     = 2'd0;
      row_reset[NUM_WAYS*2 + w*RankW +: RankW]  = RankW'(NUM_WAYS);
    end
  end

  // Shared per-way update unit. It sees only the head of the rotating row.
  always_comb begin
    head_v = val_q[0];
    head_r = rank_q[0];
    match  = way_ok_q && (WayCmpW'(way_cnt_q) == WayCmpW'(way_q));
    new_v  = head_v;
    new_r  = head_r;
    if (state_q == srripfo_pkg::ST_PASS2) begin
      case (op_q)
        srripfo_pkg::OP_HIT: begin
          if (match) new_v = srripfo_pkg::RerefHit;
        end
        srripfo_pkg::OP_VICTIM: begin
          new_v = head_v - min_q;
        end
        srripfo_pkg::OP_FILL: begin
          if (match) begin
            new_v = srripfo_pkg::RerefFill;
            new_r = '0;
          end else if (way_ok_q && head_r < old_rank_q) begin
            new_r = RankW'(head_r + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = SetAw'(set_q);
    case (state_q)
      srripfo_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        if (clr_q == SetAw'(NUM_SETS - 1)) state_d = srripfo_pkg::ST_IDLE;
      end
      srripfo_pkg::ST_IDLE: begin
        if (accept) state_d = NeedMod ? srripfo_pkg::ST_MOD : srripfo_pkg::ST_READ;
      end
      srripfo_pkg::ST_MOD: begin
        if (mod_k_q == '0) state_d = srripfo_pkg::ST_READ;
      end
      srripfo_pkg::ST_READ: begin
        mem_re  = 1'b1;
        state_d = srripfo_pkg::ST_LOAD;
      end
      srripfo_pkg::ST_LOAD: begin
        state_d = srripfo_pkg::ST_PASS1;
      end
      srripfo_pkg::ST_PASS1: begin
        if (way_last) state_d = srripfo_pkg::ST_PASS2;
      end
      srripfo_pkg::ST_PASS2: begin
        if (way_last) state_d = srripfo_pkg::ST_WRITE;
      end
      srripfo_pkg::ST_WRITE: begin
        if (out_free) begin
          mem_we  = 1'b1;
          state_d = srripfo_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srripfo_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srripfo_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      way_cnt_q   <= '0;
      mod_k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == srripfo_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (accept) mod_k_q <= ModCntW'(SetInW - 1);
      else if (state_q == srripfo_pkg::ST_MOD) mod_k_q <= mod_k_q - 1'b1;
      if (state_q == srripfo_pkg::ST_LOAD) begin
        way_cnt_q <= '0;
      end else if (state_q == srripfo_pkg::ST_PASS1 || state_q == srripfo_pkg::ST_PASS2) begin
        way_cnt_q <= way_last ? '0 : way_cnt_q + 1'b1;
      end
      if (state_q == srripfo_pkg::ST_WRITE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= srripfo_pkg::op_e'(req_i.data.operation);
      set_q    <= req_i.data.set_index;
      way_q    <= req_i.data.way_index;
      way_ok_q <= WayCmpW'(req_i.data.way_index) < WayCmpW'(NUM_WAYS);
    end
    // Restoring reduction of the set index, one shifted modulus per cycle.
    if (state_q == srripfo_pkg::ST_MOD && CmpW'(set_q) >= mod_sub) begin
      set_q <= SetInW'(CmpW'(set_q) - mod_sub);
    end
    if (state_q == srripfo_pkg::ST_LOAD) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        val_q[w]  <= rdata_q[w*2 +: 2];
        rank_q[w] <= rdata_q[NUM_WAYS*2 + w*RankW +: RankW];
      end
      min_q      <= 2'd3;
      found_q    <= 1'b0;
      victim_q   <= '0;
      old_rank_q <= RankW'(NUM_WAYS);
      res_rank_q <= RankW'(NUM_WAYS);
    end
    if (state_q == srripfo_pkg::ST_PASS1 || state_q == srripfo_pkg::ST_PASS2) begin
      for (int w = 0; w < NUM_WAYS - 1; w++) begin
        val_q[w]  <= val_q[w+1];
        rank_q[w] <= rank_q[w+1];
      end
      val_q[NUM_WAYS-1]  <= new_v;
      rank_q[NUM_WAYS-1] <= new_r;
    end
    if (state_q == srripfo_pkg::ST_PASS1) begin
      if (head_v < min_q) min_q <= head_v;
      if (match) old_rank_q <= head_r;
    end
    if (state_q == srripfo_pkg::ST_PASS2) begin
      if (match) res_rank_q <= new_r;
      if (op_q == srripfo_pkg::OP_VICTIM && new_v == 2'd0 && !found_q) begin
        found_q  <= 1'b1;
        victim_q <= way_cnt_q;
      end
    end
    if (state_q == srripfo_pkg::ST_WRITE && out_free) begin
      out_data_q.victim_way <= srripfo_pkg::WayOutW'(victim_q);
      out_data_q.fill_rank  <= way_ok_q ? srripfo_pkg::RankOutW'(res_rank_q)
                                        : srripfo_pkg::RankOutW'(NUM_WAYS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= (state_q == srripfo_pkg::ST_CLEAR) ? row_reset : row_packed;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

endmodule

`default_nettype wire
